@@ hw/rtl/frp_pkg.sv @@
// ----------------------------------------------------------------------------
// frp_pkg
// Shared types and constants of the FIFO page replacement unit.
// ----------------------------------------------------------------------------
package frp_pkg;

	localparam int SLOT_W  = 3;
	localparam int CFG_W   = 4;
	localparam int COUNT_W = 32;

	localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_WRITE = 4'b0100,
		ST_HOLD  = 4'b1000
	} frp_state_t;

	// Result of one reference, apart from the evicted page, whose width
	// follows the page width parameter.
	typedef struct packed {
		logic               fault;
		logic [SLOT_W-1:0]  slot;
		logic               evicted_valid;
		logic [COUNT_W-1:0] fault_count;
	} frp_res_t;

endpackage

@@ hw/rtl/frp_mem.sv @@
// ----------------------------------------------------------------------------
// frp_mem
// Page memory: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module frp_mem #(
	parameter int DEPTH = 8,
	parameter int AW    = 3,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/frp_ctrl.sv @@
// ----------------------------------------------------------------------------
// frp_ctrl
// Search and replacement sequencer: scans the page memory one frame a cycle,
// keeps the valid bits, the replace pointer and the fault counter.
// ----------------------------------------------------------------------------
module frp_ctrl
	import frp_pkg::*;
#(
	parameter int FRAMES    = 8,
	parameter int PAGE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [CFG_W-1:0]     frames_cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PAGE_BITS-1:0] page_number,
	input  logic                 out_free,
	output logic                 res_valid,
	output frp_res_t             res,
	output logic [PAGE_BITS-1:0] res_ev_page
);

	localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W = $clog2(FRAMES + 1);

	frp_state_t state_q;
	logic [FRAMES-1:0]    valid_q;
	logic [IDX_W-1:0]     ptr_q;
	logic [COUNT_W-1:0]   cnt_q;
	logic                 issue_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [CNT_W-1:0]     idx_q;
	logic [CNT_W-1:0]     n_q;
	logic [IDX_W-1:0]     pos_q;
	logic [PAGE_BITS-1:0] page_q;
	logic [PAGE_BITS-1:0] ev_page_q;
	frp_res_t             res_q;
	logic [PAGE_BITS-1:0] res_ev_page_q;

	logic                 accept;
	logic [CNT_W-1:0]     n_w;
	logic [IDX_W-1:0]     pos_w;
	logic [CNT_W-1:0]     pos_inc;
	logic                 hit_now;
	logic                 miss_now;
	logic                 done_now;
	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;
	logic                 wr_en;
	logic [PAGE_BITS-1:0] rd_data;
	logic [COUNT_W-1:0]   cnt_inc;
	frp_res_t             res_d;
	logic [PAGE_BITS-1:0] ev_page_d;

	frp_mem #(
		.DEPTH(FRAMES),
		.AW   (IDX_W),
		.DW   (PAGE_BITS)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(pos_q),
		.wr_data(page_q),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Clamp the register to 1..FRAMES.
	always_comb begin
		if (frames_cfg == '0) begin
			n_w = CNT_W'(1);
		end else if (32'(frames_cfg) > FRAMES) begin
			n_w = CNT_W'(FRAMES);
		end else begin
			n_w = CNT_W'(frames_cfg);
		end
	end

	// A pointer left beyond a shrunken frame count restarts at frame 0.
	assign pos_w   = (CNT_W'(ptr_q) >= n_w) ? '0 : ptr_q;
	assign pos_inc = CNT_W'(pos_q) + CNT_W'(1);
	assign cnt_inc = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + COUNT_W'(1);

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// The compare stage works in the cycle after the read issue.
	assign hit_now  = (state_q == ST_SCAN) && issue_s1 && valid_q[idx_s1]
		&& (rd_data == page_q);
	assign miss_now = (state_q == ST_SCAN) && issue_s1 && !hit_now
		&& ((CNT_W'(idx_s1) + CNT_W'(1)) == n_q);
	assign done_now = hit_now || (state_q == ST_WRITE);

	assign rd_en   = accept || ((state_q == ST_SCAN) && (idx_q < n_q));
	assign rd_addr = (state_q == ST_SCAN) ? idx_q[IDX_W-1:0] : '0;
	assign wr_en   = (state_q == ST_WRITE);

	always_comb begin
		res_d.fault         = wr_en;
		res_d.slot          = wr_en ? SLOT_W'(pos_q) : SLOT_W'(idx_s1);
		res_d.evicted_valid = wr_en && valid_q[pos_q];
		res_d.fault_count   = wr_en ? cnt_inc : cnt_q;
		ev_page_d           = (wr_en && valid_q[pos_q]) ? ev_page_q : '0;
	end

	assign res_valid   = (done_now || (state_q == ST_HOLD)) && out_free;
	assign res         = (state_q == ST_HOLD) ? res_q : res_d;
	assign res_ev_page = (state_q == ST_HOLD) ? res_ev_page_q : ev_page_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			valid_q  <= '0;
			ptr_q    <= '0;
			cnt_q    <= '0;
			issue_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						issue_s1 <= 1'b1;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					issue_s1 <= rd_en && !hit_now;
					if (hit_now) begin
						state_q <= out_free ? ST_IDLE : ST_HOLD;
					end else if (miss_now) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					valid_q[pos_q] <= 1'b1;
					ptr_q   <= (pos_inc >= n_q) ? '0 : pos_inc[IDX_W-1:0];
					cnt_q   <= cnt_inc;
					state_q <= out_free ? ST_IDLE : ST_HOLD;
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_q <= page_number;
			n_q    <= n_w;
			pos_q  <= pos_w;
			idx_q  <= CNT_W'(1);
			idx_s1 <= '0;
		end else if (rd_en) begin
			idx_q  <= idx_q + CNT_W'(1);
			idx_s1 <= idx_q[IDX_W-1:0];
		end
		// The scan passes the replace frame on its way; keep its page.
		if ((state_q == ST_SCAN) && issue_s1 && (idx_s1 == pos_q)) begin
			ev_page_q <= rd_data;
		end
		if (done_now) begin
			res_q         <= res_d;
			res_ev_page_q <= ev_page_d;
		end
	end

	a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("page memory read and written in the same cycle");

	a_res_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> out_free)
		else $error("result word issued while output register is full");

	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) && issue_s1) |-> (CNT_W'(idx_s1) < n_q))
		else $error("compare of a frame beyond the frames in use");

	a_write_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |=> valid_q[$past(pos_q)])
		else $error("replaced frame not marked valid");

	a_hit_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		hit_now |-> (valid_q[idx_s1] && (CNT_W'(idx_s1) < n_q)))
		else $error("hit reported on an empty or inactive frame");

endmodule

@@ hw/rtl/fifo_page_replacement.sv @@
// ----------------------------------------------------------------------------
// fifo_page_replacement
// FIFO page replacement unit: one page reference in, one hit/fault word out.
//
//   channel   signals                                   direction
//   input     in_valid, in_ready, page_number           in
//   output    out_valid, out_ready, fault, slot,        out
//             evicted_valid, evicted_page, fault_count
//   config    cfg_we, cfg_wdata (frames_in_use)         in
//
// A hit in frame k ends the scan of frames there; a fault scans all n
// frames, n being the clamped frames in use, and then writes the page.
// The single read port of the page memory scans one frame per cycle.
// Reset clears the valid bits, pointer, fault count and output valid flag at
// once; no clearing pass. A result word waits in the output register while
// the next word is accepted; a new reference waits while the last is scanned
// or written, or while a finished word is held back by a full output register.
// ----------------------------------------------------------------------------
module fifo_page_replacement
	import frp_pkg::*;
#(
	parameter int FRAMES    = 8,
	parameter int PAGE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PAGE_BITS-1:0] page_number,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 fault,
	output logic [SLOT_W-1:0]    slot,
	output logic                 evicted_valid,
	output logic [PAGE_BITS-1:0] evicted_page,
	output logic [COUNT_W-1:0]   fault_count
);

	logic [CFG_W-1:0]     frames_q;
	logic                 out_valid_q;
	frp_res_t             out_res_q;
	logic [PAGE_BITS-1:0] out_ev_page_q;

	logic                 out_free;
	logic                 res_valid;
	frp_res_t             res;
	logic [PAGE_BITS-1:0] res_ev_page;

	assign out_free = !out_valid_q || out_ready;

	frp_ctrl #(
		.FRAMES   (FRAMES),
		.PAGE_BITS(PAGE_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.frames_cfg (frames_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.page_number(page_number),
		.out_free   (out_free),
		.res_valid  (res_valid),
		.res        (res),
		.res_ev_page(res_ev_page)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q    <= CFG_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				frames_q <= cfg_wdata;
			end
			if (out_free) begin
				out_valid_q <= res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_res_q     <= res;
			out_ev_page_q <= res_ev_page;
		end
	end

	assign out_valid     = out_valid_q;
	assign fault         = out_res_q.fault;
	assign slot          = out_res_q.slot;
	assign evicted_valid = out_res_q.evicted_valid;
	assign evicted_page  = out_ev_page_q;
	assign fault_count   = out_res_q.fault_count;

endmodule

@@ sim/fifo_page_replacement_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_page_replacement_checker
// Watches the reference, result and configuration ports of the FIFO page
// replacement unit. Keeps its own copy of the frame table, replace pointer
// and fault count, predicts the word each reference must produce, and
// compares every accepted result word against the oldest prediction.
// ----------------------------------------------------------------------------
module fifo_page_replacement_checker
	import frp_pkg::*;
#(
	parameter int FRAMES    = 8,
	parameter int PAGE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [PAGE_BITS-1:0] page_number,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 fault,
	input  logic [SLOT_W-1:0]    slot,
	input  logic                 evicted_valid,
	input  logic [PAGE_BITS-1:0] evicted_page,
	input  logic [COUNT_W-1:0]   fault_count,
	output int                   errors,
	output int                   pending,
	output int                   hits,
	output int                   faults
);

	typedef struct packed {
		logic                 fault;
		logic [SLOT_W-1:0]    slot;
		logic                 evicted_valid;
		logic [PAGE_BITS-1:0] evicted_page;
		logic [COUNT_W-1:0]   fault_count;
	} ref_outcome_t;

	logic [PAGE_BITS-1:0] frame_page [FRAMES];
	bit                   frame_used [FRAMES];
	int                   next_victim;
	logic [COUNT_W-1:0]   fault_total;
	logic [CFG_W-1:0]     frames_cfg;
	ref_outcome_t         outcome_q [$];
	ref_outcome_t         want;
	ref_outcome_t         got;

	// Looks the page up among the frames in use and applies a FIFO
	// replacement on a miss. Updates the frame table as the unit would.
	function automatic ref_outcome_t resolve_reference(input logic [PAGE_BITS-1:0] page);
		ref_outcome_t r;
		int n;
		int pos;
		bit found;
		r = '0;
		found = 1'b0;
		n = frames_cfg;
		if (n < 1)
			n = 1;
		if (n > FRAMES)
			n = FRAMES;
		for (int i = 0; i < n; i++) begin
			if (!found && frame_used[i] && frame_page[i] == page) begin
				found = 1'b1;
				r.slot = SLOT_W'(i);
			end
		end
		if (!found) begin
			// A pointer left beyond a shrunken frame count restarts at frame 0.
			pos = next_victim;
			if (pos >= n)
				pos = 0;
			r.fault = 1'b1;
			r.slot = SLOT_W'(pos);
			if (frame_used[pos]) begin
				r.evicted_valid = 1'b1;
				r.evicted_page = frame_page[pos];
			end
			frame_page[pos] = page;
			frame_used[pos] = 1'b1;
			pos++;
			if (pos >= n)
				pos = 0;
			next_victim = pos;
			if (fault_total != COUNT_MAX)
				fault_total++;
		end
		r.fault_count = fault_total;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAMES; i++) begin
				frame_page[i] = '0;
				frame_used[i] = 1'b0;
			end
			next_victim = 0;
			fault_total = '0;
			frames_cfg = CFG_RESET;
			outcome_q.delete();
			errors = 0;
			pending = 0;
			hits = 0;
			faults = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {fault, slot, evicted_valid, evicted_page, fault_count};
				if (outcome_q.size() == 0) begin
					if (errors < 10)
						$display("ERROR %0t: result word with no reference outstanding", $realtime);
					errors++;
				end else begin
					want = outcome_q.pop_front();
					if (got.fault !== want.fault || got.slot !== want.slot ||
							got.evicted_valid !== want.evicted_valid ||
							got.evicted_page !== want.evicted_page ||
							got.fault_count !== want.fault_count) begin
						if (errors < 10) begin
							$display("ERROR %0t: expected fault=%0d slot=%0d evicted=%0d/%h count=%0d",
								$realtime, want.fault, want.slot, want.evicted_valid,
								want.evicted_page, want.fault_count);
							$display("      %0t:      got fault=%0d slot=%0d evicted=%0d/%h count=%0d",
								$realtime, got.fault, got.slot, got.evicted_valid,
								got.evicted_page, got.fault_count);
						end
						errors++;
					end
					if (want.fault)
						faults++;
					else
						hits++;
				end
			end
			if (in_valid && in_ready)
				outcome_q.push_back(resolve_reference(page_number));
			if (cfg_we)
				frames_cfg = cfg_wdata;
			pending = outcome_q.size();
		end
	end

endmodule

@@ sim/fifo_page_replacement_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_page_replacement_tb
// Drives page references into the FIFO page replacement unit under several
// frame-count settings and handshake pacings. A directed opening covers
// page extremes, out-of-range frame counts, a shrunken pointer and duplicate
// pages; random references from a small working set follow. The checker
// beside the unit predicts and compares every result word.
// ----------------------------------------------------------------------------
module fifo_page_replacement_tb;
	import frp_pkg::*;

	localparam int FRAMES      = 8;
	localparam int PAGE_BITS   = 16;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_REFS  = 140;
	localparam int PHASES      = 14;

	typedef enum int {
		PACE_FREE,
		PACE_SENDER,
		PACE_RECEIVER,
		PACE_BOTH
	} pace_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [PAGE_BITS-1:0] page_number = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 fault;
	logic [SLOT_W-1:0]    slot;
	logic                 evicted_valid;
	logic [PAGE_BITS-1:0] evicted_page;
	logic [COUNT_W-1:0]   fault_count;

	int errors;
	int pending;
	int hit_total;
	int fault_total;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;
	int settings_run = 0;

	logic [PAGE_BITS-1:0] working_set [16];
	logic [CFG_W-1:0]     frame_plan [PHASES] = '{4'd8, 4'd1, 4'd15, 4'd3, 4'd0, 4'd5, 4'd8,
		4'd12, 4'd2, 4'd7, 4'd4, 4'd6, 4'd9, 4'd8};

	fifo_page_replacement #(
		.FRAMES   (FRAMES),
		.PAGE_BITS(PAGE_BITS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.page_number  (page_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.fault        (fault),
		.slot         (slot),
		.evicted_valid(evicted_valid),
		.evicted_page (evicted_page),
		.fault_count  (fault_count)
	);

	fifo_page_replacement_checker #(
		.FRAMES   (FRAMES),
		.PAGE_BITS(PAGE_BITS)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.page_number  (page_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.fault        (fault),
		.slot         (slot),
		.evicted_valid(evicted_valid),
		.evicted_page (evicted_page),
		.fault_count  (fault_count),
		.errors       (errors),
		.pending      (pending),
		.hits         (hit_total),
		.faults       (fault_total)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Ends the run if no word moves on any port for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
				$display("fifo_page_replacement_tb failed");
				$finish;
			end
		end
	end

	task automatic set_pace(input pace_t pace);
		case (pace)
			PACE_FREE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			PACE_SENDER: begin
				send_idle_pct = 83;
				recv_stall_pct = 0;
			end
			PACE_RECEIVER: begin
				send_idle_pct = 0;
				recv_stall_pct = 83;
			end
			default: begin
				send_idle_pct = 38;
				recv_stall_pct = 38;
			end
		endcase
	endtask

	// Starts and ends at a falling edge; valid stays high after acceptance
	// so back-to-back words need no extra assignment.
	task automatic send_page(input logic [PAGE_BITS-1:0] page);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		page_number <= page;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	// The frame count is only changed with no reference in flight.
	task automatic set_frames(input logic [CFG_W-1:0] value);
		drain;
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	initial begin
		int n_active;
		int pool_size;
		int pause_at;
		logic [PAGE_BITS-1:0] page;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Fill all eight frames from empty, then wrap and evict.
		set_pace(PACE_FREE);
		send_page(16'h0000);
		send_page(16'hFFFF);
		send_page(16'h0000);
		send_page(16'h1234);
		send_page(16'hA5A5);
		send_page(16'h5A5A);
		send_page(16'h8000);
		send_page(16'h0001);
		send_page(16'h7FFF);
		send_page(16'h4321);
		send_page(16'hFFFF);

		// Three frames: page 8000 sits in frame 5 outside the search range,
		// so it faults into frame 2 and then exists twice once all frames
		// are searched again. The lowest copy must be reported.
		set_frames(4'd3);
		send_page(16'h0BAD);
		send_page(16'h0BAD);
		send_page(16'h8000);
		set_frames(4'd8);
		send_page(16'h8000);

		// A zero frame count behaves as one frame.
		set_frames(4'd0);
		send_page(16'h2222);
		send_page(16'h2222);
		send_page(16'h3333);

		// Counts above the frame total behave as all frames.
		set_frames(4'd15);
		send_page(16'h0001);
		send_page(16'hCAFE);
		send_page(16'h1111);
		send_page(16'h2221);
		send_page(16'h3331);
		send_page(16'h4441);
		send_page(16'h5551);

		// Pointer now sits at frame 6, beyond a count of four.
		set_frames(4'd4);
		send_page(16'h9999);

		for (int ph = 0; ph < PHASES; ph++) begin
			set_frames(frame_plan[ph]);
			set_pace(pace_t'(ph % 4));
			n_active = frame_plan[ph];
			if (n_active < 1)
				n_active = 1;
			if (n_active > FRAMES)
				n_active = FRAMES;
			pool_size = n_active + $urandom_range(4);
			for (int k = 0; k < 16; k++)
				working_set[k] = PAGE_BITS'($urandom);
			pause_at = $urandom_range(PHASE_REFS - 1);
			for (int k = 0; k < PHASE_REFS; k++) begin
				if (k == pause_at)
					drain;
				// Mostly a small working set so hits and faults mix.
				if ($urandom_range(99) < 15)
					page = PAGE_BITS'($urandom);
				else
					page = working_set[$urandom_range(pool_size - 1)];
				send_page(page);
			end
		end

		drain;
		repeat (20) @(negedge clk);

		$display("Ran %0d page references (%0d hits, %0d faults) over %0d frame-count writes.",
			hit_total + fault_total, hit_total, fault_total, settings_run);
		$display("Pacing mixed free flow, sender gaps, receiver stalls and both, with drained pauses.");
		if (errors == 0 && pending == 0)
			$display("fifo_page_replacement_tb passed");
		else
			$display("fifo_page_replacement_tb failed");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/frp_pkg.sv
hw/rtl/frp_mem.sv
hw/rtl/frp_ctrl.sv
hw/rtl/fifo_page_replacement.sv
sim/fifo_page_replacement_checker.sv
sim/fifo_page_replacement_tb.sv
